// ----- design/pft_pkg.sv -----
// shared types and constants for the polygon fan triangulator
package pft_pkg;

  localparam int WORD_W = 32;
  localparam int POS_W  = 31;
  localparam int VTX_W  = 26;

  localparam logic [VTX_W-1:0] VTX_STEP = VTX_W'(3);

  typedef enum logic [2:0] {
    PH_FIRST  = 3'b001,
    PH_SECOND = 3'b010,
    PH_FAN    = 3'b100
  } phase_t;

endpackage

// ----- design/pft_corner_if.sv -----
// request channel carrying one polygon corner index word
interface pft_corner_if import pft_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] index_word;
  logic                     last_of_mesh;

  modport source (output valid, index_word, last_of_mesh, input ready);
  modport sink   (input valid, index_word, last_of_mesh, output ready);

endinterface

// ----- design/pft_triangle_if.sv -----
// request channel carrying one fan triangle
interface pft_triangle_if import pft_pkg::*; #(
  parameter int CORNER_BITS = 24
) ();

  logic                   valid;
  logic                   ready;
  logic [POS_W-1:0]       pos_index_a;
  logic [POS_W-1:0]       pos_index_b;
  logic [POS_W-1:0]       pos_index_c;
  logic [CORNER_BITS-1:0] corner_a;
  logic [CORNER_BITS-1:0] corner_b;
  logic [CORNER_BITS-1:0] corner_c;
  logic [VTX_W-1:0]       first_output_vertex;
  logic                   closes_polygon;

  modport source (
    output valid, pos_index_a, pos_index_b, pos_index_c, corner_a, corner_b, corner_c,
           first_output_vertex, closes_polygon,
    input  ready
  );
  modport sink (
    input  valid, pos_index_a, pos_index_b, pos_index_c, corner_a, corner_b, corner_c,
           first_output_vertex, closes_polygon,
    output ready
  );

endinterface

// ----- design/polygon_fan_triangulator.sv -----
// polygon fan triangulator: corner index stream in, fan triangles out
//
// corners: one request per polygon corner. index_word with its sign bit set
//   closes the polygon; its position index is then the bitwise inverse.
//   last_of_mesh clears the polygon state and both counters after the corner.
// triangles: one request per corner from the third corner of a polygon on,
//   holding first, previous and current corner plus the base output vertex.
// A polygon closed in its first or second corner gives no triangle.
// An accepted corner's triangle is valid in the cycle after it, held
//   in a single result register. Throughput is one corner per cycle; the corner
//   channel stays ready while the result register is empty or being taken.
// When the receiver stalls, the pending triangle holds and the corner
//   channel drops ready until it is taken.
// Reset (rst, synchronous) empties the result register, returns to the
//   first-corner phase and clears the corner and vertex counters.
module polygon_fan_triangulator import pft_pkg::*; #(
  parameter int CORNER_BITS = 24
) (
  input logic              clk,
  input logic              rst,
  pft_corner_if.sink       corners,
  pft_triangle_if.source   triangles
);

  phase_t                 phase;
  phase_t                 phase_next;
  logic [POS_W-1:0]       first_pos;
  logic [POS_W-1:0]       first_pos_next;
  logic [CORNER_BITS-1:0] first_num;
  logic [CORNER_BITS-1:0] first_num_next;
  logic [POS_W-1:0]       prev_pos;
  logic [POS_W-1:0]       prev_pos_next;
  logic [CORNER_BITS-1:0] prev_num;
  logic [CORNER_BITS-1:0] prev_num_next;
  logic [CORNER_BITS-1:0] corner_count;
  logic [CORNER_BITS-1:0] corner_count_next;
  logic [VTX_W-1:0]       vertex_count;
  logic [VTX_W-1:0]       vertex_count_next;

  logic             accept;
  logic             closes;
  logic [POS_W-1:0] pos;
  logic             emit;

  assign corners.ready = !triangles.valid || triangles.ready;
  assign accept        = corners.valid && corners.ready;
  assign closes        = corners.index_word[WORD_W-1];
  assign pos           = closes ? ~corners.index_word[POS_W-1:0]
                                :  corners.index_word[POS_W-1:0];
  assign emit          = (phase == PH_FAN);

  always_comb begin
    phase_next        = phase;
    first_pos_next    = first_pos;
    first_num_next    = first_num;
    prev_pos_next     = prev_pos;
    prev_num_next     = prev_num;
    vertex_count_next = vertex_count;
    corner_count_next = corner_count + CORNER_BITS'(1);
    unique case (phase)
      PH_SECOND: begin
        if (closes) begin
          phase_next = PH_FIRST;
        end else begin
          prev_pos_next = pos;
          prev_num_next = corner_count;
          phase_next    = PH_FAN;
        end
      end
      PH_FAN: begin
        vertex_count_next = vertex_count + VTX_STEP;
        if (closes) begin
          phase_next = PH_FIRST;
        end else begin
          prev_pos_next = pos;
          prev_num_next = corner_count;
        end
      end
      default: begin
        if (closes) begin
          phase_next = PH_FIRST;
        end else begin
          first_pos_next = pos;
          first_num_next = corner_count;
          phase_next     = PH_SECOND;
        end
      end
    endcase
    if (corners.last_of_mesh) begin
      phase_next        = PH_FIRST;
      first_pos_next    = '0;
      first_num_next    = '0;
      prev_pos_next     = '0;
      prev_num_next     = '0;
      corner_count_next = '0;
      vertex_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_FIRST;
      first_pos       <= '0;
      first_num       <= '0;
      prev_pos        <= '0;
      prev_num        <= '0;
      corner_count    <= '0;
      vertex_count    <= '0;
      triangles.valid <= 1'b0;
    end else begin
      if (accept) begin
        phase           <= phase_next;
        first_pos       <= first_pos_next;
        first_num       <= first_num_next;
        prev_pos        <= prev_pos_next;
        prev_num        <= prev_num_next;
        corner_count    <= corner_count_next;
        vertex_count    <= vertex_count_next;
        triangles.valid <= emit;
      end else if (triangles.ready) begin
        triangles.valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      triangles.pos_index_a         <= first_pos;
      triangles.pos_index_b         <= prev_pos;
      triangles.pos_index_c         <= pos;
      triangles.corner_a            <= first_num;
      triangles.corner_b            <= prev_num;
      triangles.corner_c            <= corner_count;
      triangles.first_output_vertex <= vertex_count;
      triangles.closes_polygon      <= closes;
    end
  end

`ifndef NO_ASSERTIONS
  a_reset_state: assert property (@(posedge clk)
    rst |=> phase == PH_FIRST && corner_count == '0 && vertex_count == '0 && !triangles.valid)
    else $error("state not cleared by reset");

  a_mesh_end: assert property (@(posedge clk) disable iff (rst)
    accept && corners.last_of_mesh |=>
      phase == PH_FIRST && corner_count == '0 && vertex_count == '0)
    else $error("mesh end did not clear polygon state");

  a_no_triangle: assert property (@(posedge clk) disable iff (rst)
    accept && phase != PH_FAN |=> !triangles.valid)
    else $error("triangle produced before third corner");

  a_triangle_base: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_FAN |=>
      triangles.valid && triangles.first_output_vertex == $past(vertex_count))
    else $error("fan corner did not give a triangle with the running base vertex");
`endif

endmodule

// ----- tb/sv/polygon_fan_triangulator_tb.sv -----
// testbench for the polygon fan triangulator: directed and random corner streams
`timescale 1ns / 100ps

module polygon_fan_triangulator_tb;
  import pft_pkg::*;

  localparam int CORNER_BITS = 24;
  localparam int DRAIN_LIMIT = 20000;
  localparam int PRINT_LIMIT = 60;

  typedef struct packed {
    logic [POS_W-1:0]       pos_a;
    logic [POS_W-1:0]       pos_b;
    logic [POS_W-1:0]       pos_c;
    logic [CORNER_BITS-1:0] corner_a;
    logic [CORNER_BITS-1:0] corner_b;
    logic [CORNER_BITS-1:0] corner_c;
    logic [VTX_W-1:0]       base_vertex;
    logic                   closes;
  } triangle_t;

  logic clk = 1'b0;
  logic rst;

  pft_corner_if corner_bus ();
  pft_triangle_if #(.CORNER_BITS(CORNER_BITS)) tri_bus ();

  polygon_fan_triangulator #(.CORNER_BITS(CORNER_BITS)) dut (
    .clk       (clk),
    .rst       (rst),
    .corners   (corner_bus),
    .triangles (tri_bus)
  );

  triangle_t expected_triangles[$];
  int error_count = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;

  phase_t                 fan_phase;
  logic [POS_W-1:0]       first_pos;
  logic [POS_W-1:0]       prev_pos;
  logic [CORNER_BITS-1:0] first_corner;
  logic [CORNER_BITS-1:0] prev_corner;
  logic [CORNER_BITS-1:0] corner_count;
  logic [VTX_W-1:0]       vertex_count;

  always #10 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (error_count < PRINT_LIMIT) $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic clear_fan_state();
    fan_phase    = PH_FIRST;
    first_pos    = '0;
    prev_pos     = '0;
    first_corner = '0;
    prev_corner  = '0;
    corner_count = '0;
    vertex_count = '0;
  endtask

  task automatic predict_corner(input logic [WORD_W-1:0] word, input logic last);
    logic                   closes;
    logic [POS_W-1:0]       pos;
    logic [CORNER_BITS-1:0] cnum;
    triangle_t              tri_exp;
    closes = word[WORD_W-1];
    pos    = closes ? ~word[POS_W-1:0] : word[POS_W-1:0];
    cnum   = corner_count;
    case (fan_phase)
      PH_SECOND: begin
        if (closes) begin
          fan_phase = PH_FIRST;
        end else begin
          prev_pos    = pos;
          prev_corner = cnum;
          fan_phase   = PH_FAN;
        end
      end
      PH_FAN: begin
        tri_exp.pos_a       = first_pos;
        tri_exp.pos_b       = prev_pos;
        tri_exp.pos_c       = pos;
        tri_exp.corner_a    = first_corner;
        tri_exp.corner_b    = prev_corner;
        tri_exp.corner_c    = cnum;
        tri_exp.base_vertex = vertex_count;
        tri_exp.closes      = closes;
        expected_triangles.insert(expected_triangles.size(), tri_exp);
        vertex_count = vertex_count + VTX_STEP;
        if (closes) begin
          fan_phase = PH_FIRST;
        end else begin
          prev_pos    = pos;
          prev_corner = cnum;
        end
      end
      default: begin
        if (!closes) begin
          first_pos    = pos;
          first_corner = cnum;
          fan_phase    = PH_SECOND;
        end else begin
          fan_phase = PH_FIRST;
        end
      end
    endcase
    corner_count = cnum + CORNER_BITS'(1);
    if (last) clear_fan_state();
  endtask

  task automatic check_triangle();
    triangle_t e;
    if (expected_triangles.size() == 0) begin
      report_mismatch($sformatf("unexpected triangle c=%0d", tri_bus.pos_index_c));
    end else begin
      e = expected_triangles.pop_front();
      if (tri_bus.pos_index_a !== e.pos_a)
        report_mismatch($sformatf("pos_index_a %h exp %h", tri_bus.pos_index_a, e.pos_a));
      if (tri_bus.pos_index_b !== e.pos_b)
        report_mismatch($sformatf("pos_index_b %h exp %h", tri_bus.pos_index_b, e.pos_b));
      if (tri_bus.pos_index_c !== e.pos_c)
        report_mismatch($sformatf("pos_index_c %h exp %h", tri_bus.pos_index_c, e.pos_c));
      if (tri_bus.corner_a !== e.corner_a)
        report_mismatch($sformatf("corner_a %0d exp %0d", tri_bus.corner_a, e.corner_a));
      if (tri_bus.corner_b !== e.corner_b)
        report_mismatch($sformatf("corner_b %0d exp %0d", tri_bus.corner_b, e.corner_b));
      if (tri_bus.corner_c !== e.corner_c)
        report_mismatch($sformatf("corner_c %0d exp %0d", tri_bus.corner_c, e.corner_c));
      if (tri_bus.first_output_vertex !== e.base_vertex)
        report_mismatch($sformatf("first_output_vertex %0d exp %0d",
                                  tri_bus.first_output_vertex, e.base_vertex));
      if (tri_bus.closes_polygon !== e.closes)
        report_mismatch($sformatf("closes_polygon %b exp %b", tri_bus.closes_polygon, e.closes));
    end
  endtask

  // triangle check first, then the new corner request, so the queue stays in order
  always @(posedge clk) begin
    if (rst) begin
      clear_fan_state();
    end else begin
      if (tri_bus.valid === 1'b1 && tri_bus.ready === 1'b1) check_triangle();
      if (corner_bus.valid === 1'b1 && corner_bus.ready === 1'b1)
        predict_corner(corner_bus.index_word, corner_bus.last_of_mesh);
    end
  end

  always @(posedge clk) begin
    tri_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  task automatic send_corner(input logic [WORD_W-1:0] word, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      corner_bus.valid <= 1'b0;
      @(posedge clk);
    end
    corner_bus.valid        <= 1'b1;
    corner_bus.index_word   <= word;
    corner_bus.last_of_mesh <= last;
    @(posedge clk);
    while (corner_bus.ready !== 1'b1) @(posedge clk);
  endtask

  function automatic logic [POS_W-1:0] pick_position();
    case ($urandom_range(7))
      0:       return '0;
      1:       return {POS_W{1'b1}};
      2:       return POS_W'($urandom_range(255));
      default: return POS_W'($urandom());
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] encode(input logic [POS_W-1:0] pos, input bit closes);
    return closes ? {1'b1, ~pos} : {1'b0, pos};
  endfunction

  task automatic send_polygon(input int corners_n, inout int sent);
    logic [POS_W-1:0] pos;
    for (int i = 0; i < corners_n; i++) begin
      pos = pick_position();
      send_corner(encode(pos, i == corners_n - 1), $urandom_range(99) < 2);
      sent++;
    end
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (expected_triangles.size() != 0) @(posedge clk);
  endtask

  task automatic test_basic_triangle();
    send_corner(encode(31'd5, 1'b0), 1'b0);
    send_corner(encode(31'd7, 1'b0), 1'b0);
    send_corner(encode(31'd9, 1'b1), 1'b0);
    send_corner(encode(31'd0, 1'b0), 1'b0);
    send_corner(encode(31'd0, 1'b0), 1'b0);
    send_corner(encode(31'd0, 1'b1), 1'b0);
  endtask

  task automatic test_early_close();
    send_corner(encode(31'd3, 1'b1), 1'b0);
    send_corner(encode(31'd4, 1'b0), 1'b0);
    send_corner(encode(31'd6, 1'b1), 1'b0);
    send_corner(encode(31'd11, 1'b0), 1'b0);
    send_corner(encode(31'd12, 1'b0), 1'b0);
    send_corner(encode(31'd13, 1'b1), 1'b0);
  endtask

  task automatic test_index_extremes();
    send_corner(encode({POS_W{1'b1}}, 1'b0), 1'b0);
    send_corner(encode('0, 1'b0), 1'b0);
    send_corner(encode({POS_W{1'b1}}, 1'b1), 1'b0);
  endtask

  task automatic test_long_fan();
    int sent;
    sent = 0;
    send_polygon(8, sent);
  endtask

  task automatic test_mesh_end();
    send_corner(encode(31'd1, 1'b0), 1'b0);
    send_corner(encode(31'd2, 1'b0), 1'b0);
    send_corner(encode(31'd3, 1'b0), 1'b0);
    send_corner(encode(31'd4, 1'b0), 1'b1);
    send_corner(encode(31'd20, 1'b0), 1'b0);
    send_corner(encode(31'd21, 1'b0), 1'b0);
    send_corner(encode(31'd22, 1'b1), 1'b1);
    send_corner(encode(31'd30, 1'b0), 1'b1);
    send_corner(encode(31'd31, 1'b0), 1'b0);
    send_corner(encode(31'd32, 1'b0), 1'b0);
    send_corner(encode(31'd33, 1'b1), 1'b0);
  endtask

  task automatic test_random_polygons(input int count, input int src_pct, input int snk_pct);
    int sent;
    int pick;
    sent = 0;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        send_corner($urandom(), $urandom_range(9) == 0);
        sent++;
      end else if (pick < 22) begin
        send_polygon($urandom_range(1, 2), sent);
      end else if (pick < 27) begin
        send_polygon($urandom_range(11, 20), sent);
      end else begin
        send_polygon($urandom_range(3, 10), sent);
      end
      if ($urandom_range(99) < 5) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end else begin
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
      end
    end
  endtask

  initial begin
    int waited;
    rst                     <= 1'b1;
    corner_bus.valid        <= 1'b0;
    corner_bus.index_word   <= '0;
    corner_bus.last_of_mesh <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_idle_pct = 34;
    snk_idle_pct = 68;
    test_basic_triangle();
    test_early_close();
    test_index_extremes();
    test_long_fan();
    test_mesh_end();

    test_random_polygons(700, 34, 68);
    corner_bus.valid <= 1'b0;
    wait_drained();
    test_random_polygons(700, 68, 34);
    test_random_polygons(700, 0, 0);
    corner_bus.valid <= 1'b0;

    @(posedge clk);
    waited = 0;
    while (expected_triangles.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (expected_triangles.size() != 0)
      report_mismatch($sformatf("%0d triangles never arrived", expected_triangles.size()));
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
